// File: design/assert_macros.svh
// Assertion macros shared by the line editor RTL.
// Included by the controller and datapath modules; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define GBLE_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define GBLE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: design/gble_pkg.sv
// Shared types, key codes and the key decoder of the gap buffer line editor.
// Used by gble_ctrl, gble_dp and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gble_pkg;

  localparam int KEY_W       = 9;
  localparam int CHAR_W      = 8;
  localparam int POS_W       = 7;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  localparam logic [KEY_W-1:0] KEY_HOME      = 9'd1;
  localparam logic [KEY_W-1:0] KEY_BACK      = 9'd2;
  localparam logic [KEY_W-1:0] KEY_DEL       = 9'd4;
  localparam logic [KEY_W-1:0] KEY_END       = 9'd5;
  localparam logic [KEY_W-1:0] KEY_FWD       = 9'd6;
  localparam logic [KEY_W-1:0] KEY_BKSP      = 9'd8;
  localparam logic [KEY_W-1:0] KEY_ENTER     = 9'd10;
  localparam logic [KEY_W-1:0] KEY_KILL      = 9'd21;
  localparam logic [KEY_W-1:0] KEY_BKSP_ALT  = 9'd127;
  localparam logic [KEY_W-1:0] KEY_NONE      = 9'd257;
  localparam logic [KEY_W-1:0] KEY_ARROW_UP  = 9'd258;
  localparam logic [KEY_W-1:0] KEY_ARROW_DN  = 9'd259;
  localparam logic [KEY_W-1:0] KEY_ARROW_RT  = 9'd260;
  localparam logic [KEY_W-1:0] KEY_ARROW_LT  = 9'd261;

  typedef enum logic [3:0] {
    KC_NONE  = 4'd0,
    KC_LEFT  = 4'd1,
    KC_RIGHT = 4'd2,
    KC_HOME  = 4'd3,
    KC_END   = 4'd4,
    KC_DEL   = 4'd5,
    KC_BKSP  = 4'd6,
    KC_ENTER = 4'd7,
    KC_KILL  = 4'd8,
    KC_INS   = 4'd9
  } kclass_t;

  typedef struct packed {
    logic load_key;
    logic update;
    logic move_step;
    logic edit;
    logic emit_status;
    logic read_char;
    logic emit_char;
    logic emit_empty;
  } gble_cmd_t;

  typedef struct packed {
    kclass_t kclass;
    logic    move_done;
    logic    out_free;
    logic    line_zero;
    logic    last_char;
  } gble_status_t;

  function automatic kclass_t decode_key(input logic [KEY_W-1:0] key);
    kclass_t kc;
    unique case (key)
      KEY_HOME:                     kc = KC_HOME;
      KEY_BACK, KEY_ARROW_LT:       kc = KC_LEFT;
      KEY_DEL:                      kc = KC_DEL;
      KEY_END:                      kc = KC_END;
      KEY_FWD, KEY_ARROW_RT:        kc = KC_RIGHT;
      KEY_BKSP, KEY_BKSP_ALT:       kc = KC_BKSP;
      KEY_ENTER:                    kc = KC_ENTER;
      KEY_KILL:                     kc = KC_KILL;
      KEY_NONE, KEY_ARROW_UP,
      KEY_ARROW_DN:                 kc = KC_NONE;
      default:                      kc = KC_INS;
    endcase
    return kc;
  endfunction

endpackage

`default_nettype wire

// File: design/gble_ctrl.sv
// Controller state machine of the line editor: sequences key handling.
// Depends on gble_pkg and assert_macros.svh; drives gble_dp by commands.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module gble_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire gble_pkg::gble_status_t status_i,
  output gble_pkg::gble_cmd_t         cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_UPDATE = 8'b0000_0010,
    S_MOVE   = 8'b0000_0100,
    S_EDIT   = 8'b0000_1000,
    S_STATUS = 8'b0001_0000,
    S_LREAD  = 8'b0010_0000,
    S_LEMIT  = 8'b0100_0000,
    S_LEMPTY = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd_o.load_key = 1'b1;
          state_nxt      = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        unique case (status_i.kclass)
          gble_pkg::KC_DEL, gble_pkg::KC_BKSP, gble_pkg::KC_INS: state_nxt = S_MOVE;
          gble_pkg::KC_ENTER: state_nxt = status_i.line_zero ? S_LEMPTY : S_LREAD;
          default: state_nxt = S_STATUS;
        endcase
      end
      S_MOVE: begin
        cmd_o.move_step = 1'b1;
        if (status_i.move_done) begin
          state_nxt = S_EDIT;
        end
      end
      S_EDIT: begin
        cmd_o.edit = 1'b1;
        state_nxt  = S_STATUS;
      end
      S_STATUS: begin
        if (status_i.out_free) begin
          cmd_o.emit_status = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      S_LREAD: begin
        cmd_o.read_char = 1'b1;
        state_nxt       = S_LEMIT;
      end
      S_LEMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit_char = 1'b1;
          state_nxt       = status_i.last_char ? S_IDLE : S_LREAD;
        end
      end
      S_LEMPTY: begin
        if (status_i.out_free) begin
          cmd_o.emit_empty = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `GBLE_ASSERT_IMPL(a_edit_after_drain, clk, rst_n, state_r == S_EDIT, $past(status_i.move_done), "edit entered before gap move drained")

endmodule

`default_nettype wire

// File: design/gble_dp.sv
// Datapath of the line editor: text store, gap pointers, cursor, output register.
// Depends on gble_pkg and assert_macros.svh; commanded by gble_ctrl.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module gble_dp #(
  parameter int CAPACITY = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [gble_pkg::KEY_W-1:0]        key_i,
  input  wire gble_pkg::gble_cmd_t               cmd_i,
  output gble_pkg::gble_status_t                 status_o,
  input  wire logic                              out_tready_i,
  output logic                                   out_valid_o,
  output logic                                   out_kind_o,
  output logic [gble_pkg::CHAR_W-1:0]            out_char_o,
  output logic [gble_pkg::POS_W-1:0]             out_pos_o,
  output logic [gble_pkg::POS_W-1:0]             out_len_o,
  output logic                                   out_refused_o,
  output logic                                   out_empty_o,
  output logic                                   out_last_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam logic [gble_pkg::POS_W-1:0] CAP_P = gble_pkg::POS_W'(CAPACITY);

  logic [gble_pkg::CHAR_W-1:0] mem [CAPACITY];

  logic [gble_pkg::POS_W-1:0] gs_r, gs_nxt, ge_r, ge_nxt, cur_r, cur_nxt;
  logic [gble_pkg::POS_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [gble_pkg::CHAR_W-1:0] key_r, key_nxt, rd_data_r;
  gble_pkg::kclass_t kclass_r, kclass_nxt;
  logic refused_r, refused_nxt;
  logic wr_pend_r, wr_pend_nxt;
  logic [AW-1:0] wr_addr_r, wr_addr_nxt;

  logic out_valid_r, out_valid_nxt;
  logic out_kind_r, out_kind_nxt, out_refused_r, out_refused_nxt;
  logic out_empty_r, out_empty_nxt, out_last_r, out_last_nxt;
  logic [gble_pkg::CHAR_W-1:0] out_char_r, out_char_nxt;
  logic [gble_pkg::POS_W-1:0] out_pos_r, out_pos_nxt, out_len_r, out_len_nxt;

  logic                        mem_we, mem_re;
  logic [AW-1:0]               mem_waddr, mem_raddr;
  logic [gble_pkg::CHAR_W-1:0] mem_wdata;

  logic [gble_pkg::POS_W-1:0] len_w, line_idx;
  logic at_cursor, fwd, out_free, last_char;

  assign len_w     = gs_r + (CAP_P - ge_r);
  assign at_cursor = (cur_r == gs_r);
  assign fwd       = (cur_r > gs_r);
  assign line_idx  = (rd_idx_r < gs_r) ? rd_idx_r : ge_r + (rd_idx_r - gs_r);
  assign out_free  = !out_valid_r || out_tready_i;
  assign last_char = ((rd_idx_r + 1'b1) == len_w);

  assign status_o.kclass    = kclass_r;
  assign status_o.move_done = at_cursor && !wr_pend_r;
  assign status_o.out_free  = out_free;
  assign status_o.line_zero = (len_w == '0);
  assign status_o.last_char = last_char;

  always_comb begin
    gs_nxt          = gs_r;
    ge_nxt          = ge_r;
    cur_nxt         = cur_r;
    rd_idx_nxt      = rd_idx_r;
    key_nxt         = key_r;
    kclass_nxt      = kclass_r;
    refused_nxt     = refused_r;
    wr_pend_nxt     = 1'b0;
    wr_addr_nxt     = wr_addr_r;
    mem_we          = wr_pend_r;
    mem_waddr       = wr_addr_r;
    mem_wdata       = rd_data_r;
    mem_re          = 1'b0;
    mem_raddr       = '0;
    out_valid_nxt   = out_valid_r && !out_tready_i;
    out_kind_nxt    = out_kind_r;
    out_char_nxt    = out_char_r;
    out_pos_nxt     = out_pos_r;
    out_len_nxt     = out_len_r;
    out_refused_nxt = out_refused_r;
    out_empty_nxt   = out_empty_r;
    out_last_nxt    = out_last_r;

    priority if (cmd_i.load_key) begin
      key_nxt     = key_i[gble_pkg::CHAR_W-1:0];
      kclass_nxt  = gble_pkg::decode_key(key_i);
      refused_nxt = 1'b0;
      rd_idx_nxt  = '0;
    end else if (cmd_i.update) begin
      unique case (kclass_r)
        gble_pkg::KC_LEFT:  if (cur_r != '0) cur_nxt = cur_r - 1'b1;
        gble_pkg::KC_RIGHT: if (cur_r < len_w) cur_nxt = cur_r + 1'b1;
        gble_pkg::KC_HOME:  cur_nxt = '0;
        gble_pkg::KC_END:   cur_nxt = len_w;
        gble_pkg::KC_KILL: begin
          gs_nxt  = '0;
          ge_nxt  = CAP_P;
          cur_nxt = '0;
        end
        default: ;
      endcase
    end else if (cmd_i.move_step) begin
      // one character crosses the gap per cycle; its write lands in the next cycle
      if (!at_cursor) begin
        mem_re      = 1'b1;
        wr_pend_nxt = 1'b1;
        if (fwd) begin
          mem_raddr   = ge_r[AW-1:0];
          wr_addr_nxt = gs_r[AW-1:0];
          gs_nxt      = gs_r + 1'b1;
          ge_nxt      = ge_r + 1'b1;
        end else begin
          mem_raddr   = AW'(gs_r - 1'b1);
          wr_addr_nxt = AW'(ge_r - 1'b1);
          gs_nxt      = gs_r - 1'b1;
          ge_nxt      = ge_r - 1'b1;
        end
      end
    end else if (cmd_i.edit) begin
      unique case (kclass_r)
        gble_pkg::KC_DEL: if (ge_r < CAP_P) ge_nxt = ge_r + 1'b1;
        gble_pkg::KC_BKSP: begin
          if (gs_r != '0) begin
            gs_nxt  = gs_r - 1'b1;
            cur_nxt = cur_r - 1'b1;
          end
        end
        gble_pkg::KC_INS: begin
          if (gs_r >= ge_r) begin
            refused_nxt = 1'b1;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = gs_r[AW-1:0];
            mem_wdata = key_r;
            gs_nxt    = gs_r + 1'b1;
            cur_nxt   = cur_r + 1'b1;
          end
        end
        default: ;
      endcase
    end else if (cmd_i.emit_status) begin
      out_valid_nxt   = 1'b1;
      out_kind_nxt    = 1'b0;
      out_char_nxt    = '0;
      out_pos_nxt     = cur_r;
      out_len_nxt     = len_w;
      out_refused_nxt = refused_r;
      out_empty_nxt   = 1'b0;
      out_last_nxt    = 1'b1;
    end else if (cmd_i.read_char) begin
      mem_re    = 1'b1;
      mem_raddr = line_idx[AW-1:0];
    end else if (cmd_i.emit_char) begin
      out_valid_nxt   = 1'b1;
      out_kind_nxt    = 1'b1;
      out_char_nxt    = rd_data_r;
      out_pos_nxt     = rd_idx_r;
      out_len_nxt     = len_w;
      out_refused_nxt = 1'b0;
      out_empty_nxt   = 1'b0;
      out_last_nxt    = last_char;
      rd_idx_nxt      = rd_idx_r + 1'b1;
      if (last_char) begin
        gs_nxt  = '0;
        ge_nxt  = CAP_P;
        cur_nxt = '0;
      end
    end else if (cmd_i.emit_empty) begin
      out_valid_nxt   = 1'b1;
      out_kind_nxt    = 1'b1;
      out_char_nxt    = '0;
      out_pos_nxt     = '0;
      out_len_nxt     = '0;
      out_refused_nxt = 1'b0;
      out_empty_nxt   = 1'b1;
      out_last_nxt    = 1'b1;
      gs_nxt          = '0;
      ge_nxt          = CAP_P;
      cur_nxt         = '0;
    end else begin
      // hold
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gs_r        <= '0;
      ge_r        <= CAP_P;
      cur_r       <= '0;
      refused_r   <= 1'b0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      gs_r        <= gs_nxt;
      ge_r        <= ge_nxt;
      cur_r       <= cur_nxt;
      refused_r   <= refused_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r      <= rd_idx_nxt;
    key_r         <= key_nxt;
    kclass_r      <= kclass_nxt;
    wr_addr_r     <= wr_addr_nxt;
    out_kind_r    <= out_kind_nxt;
    out_char_r    <= out_char_nxt;
    out_pos_r     <= out_pos_nxt;
    out_len_r     <= out_len_nxt;
    out_refused_r <= out_refused_nxt;
    out_empty_r   <= out_empty_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid_o   = out_valid_r;
  assign out_kind_o    = out_kind_r;
  assign out_char_o    = out_char_r;
  assign out_pos_o     = out_pos_r;
  assign out_len_o     = out_len_r;
  assign out_refused_o = out_refused_r;
  assign out_empty_o   = out_empty_r;
  assign out_last_o    = out_last_r;

  `GBLE_ASSERT_ALWAYS(a_gap_order, clk, rst_n, gs_r <= ge_r, "gap start passed gap end")
  `GBLE_ASSERT_ALWAYS(a_cursor_in_line, clk, rst_n, cur_r <= len_w, "cursor beyond line end")
  `GBLE_ASSERT_IMPL(a_no_move_hazard, clk, rst_n, wr_pend_r && mem_re, wr_addr_r != mem_raddr, "gap move reads an entry still being written")
  `GBLE_ASSERT_IMPL(a_readout_in_line, clk, rst_n, cmd_i.emit_char, rd_idx_r < len_w, "line readout past line end")

endmodule

`default_nettype wire

// File: design/gap_buffer_line_editor.sv
// Top level of the gap buffer line editor: stream ports, controller and datapath.
// Depends on gble_pkg, gble_ctrl and gble_dp.
`timescale 1ns / 1ps
`default_nettype none

// Line editor over a gap buffer of CAPACITY characters. Each input transaction
// carries one key code, which the block decodes; it answers every key but Enter with one
// status transaction (kind 0) that reports the cursor position, the line length
// and whether an insert was refused because the store was full. Enter streams
// the line out as one transaction per character (kind 1, tlast on the final
// one), or a single transaction with line_empty set when nothing is held, and
// then empties the buffer. Cursor moves only update a pointer; the gap is moved
// to the cursor lazily, just before a delete, backspace or insert. A key that
// only moves the cursor passes through the update and status states; an edit
// also passes through the gap move and the edit state, where the text store
// moves one character per cycle across the gap, up to CAPACITY, and the write
// of the last moved character lands in the following cycle. Enter reads each
// character from the store into a register before it is emitted. A new key is
// accepted only once the previous key's transactions are all handed to the
// output register, which lets the last result wait for the downstream side
// while the next key arrives.
// No clearing pass is needed after reset: store entries are only read after
// they were written.
module gap_buffer_line_editor #(
  parameter int CAPACITY = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input channel
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [gble_pkg::IN_TDATA_W-1:0]     in_tdata,   // [8:0] key_code, [15:9] zero
  // result channel
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [gble_pkg::OUT_TDATA_W-1:0]         out_tdata,  // [7:0] char_out,
                                                               // [14:8] cursor_pos,
                                                               // [21:15] line_length,
                                                               // [22] insert_refused,
                                                               // [23] line_empty
  output logic                                     out_tuser,  // [0] kind
  output logic                                     out_tlast
);

  gble_pkg::gble_cmd_t    cmd;
  gble_pkg::gble_status_t status;

  logic                        out_kind, out_refused, out_empty;
  logic [gble_pkg::CHAR_W-1:0] out_char;
  logic [gble_pkg::POS_W-1:0]  out_pos, out_len;

  // sequence each key: decode, gap move, edit, result emission
  gble_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // text store, gap pointers, cursor and output register
  gble_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .key_i         (in_tdata[gble_pkg::KEY_W-1:0]),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_tready_i  (out_tready),
    .out_valid_o   (out_tvalid),
    .out_kind_o    (out_kind),
    .out_char_o    (out_char),
    .out_pos_o     (out_pos),
    .out_len_o     (out_len),
    .out_refused_o (out_refused),
    .out_empty_o   (out_empty),
    .out_last_o    (out_tlast)
  );

  // pack the result fields, lowest field in the lowest bits
  assign out_tdata = {out_empty, out_refused, out_len, out_pos, out_char};
  assign out_tuser = out_kind;

endmodule

`default_nettype wire
